FILE: rtl/sst_pkg.sv
`timescale 1ns / 1ps
package sst_pkg;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF = 32;
    localparam int WIDTH_DEF = 32;

    // Fixed field widths of the ports.
    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;
    localparam int POS_W = 5;
    localparam int CNT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_FIRST  = 3'd3,
        OP_NEXT   = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_END      = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the operation and value of a transfer
        logic compare;  // register the per-entry compares and the cursor read
        logic execute;  // update the table and register the result
    } t_ctrl_cmd;

endpackage

FILE: rtl/sorted_set_table_core.sv
`timescale 1ns / 1ps
// Sorted set table: keeps up to DEPTH distinct unsigned values in ascending
// order and runs one operation per transfer (insert, remove, search, first,
// next).
//
// Command channel: an operation and a value are transferred at a rising edge
// where start is high and busy is low. busy is high for the one cycle in
// which every stored entry is compared against the value in parallel.
//
// Result channel: o_valid is high for exactly one cycle with status, element,
// position and count; the receiver cannot stall it and must take it then.
// The result is registered at the edge that ends the table update cycle. A
// new command may be transferred at that edge, so its compare runs while the
// previous result is shown; a steady stream is paced by the compare cycle
// followed by the shift/update cycle of the row of entry registers.
//
// Reset (i_rst_n low, synchronous) empties the set and clears the read
// cursor; the entry registers themselves are not cleared, since only entries
// below the count are ever read.
module sorted_set_table_core
    import sst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OP_W-1:0]  i_op,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_valid,
    output logic [ST_W-1:0]  o_status,
    output logic [VAL_W-1:0] o_elem_out,
    output logic [POS_W-1:0] o_position,
    output logic [CNT_W-1:0] o_count
);

    t_ctrl_cmd w_cmd;

    // The controller sequences capture, compare and update.
    sst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the sorted row of entries, count and cursor.
    sst_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_op       (i_op),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_elem_out (o_elem_out),
        .o_position (o_position),
        .o_count    (o_count)
    );

endmodule

FILE: rtl/sst_ctrl.sv
`timescale 1ns / 1ps
module sst_ctrl
    import sst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Busy only while compares are formed; the execute cycle takes the next
    // transfer so that the table update and the new capture share one edge.
    assign busy     = (r_state == S_CMP);
    assign w_accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_EXEC;
            S_EXEC:  n_state = w_accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load    = w_accept;
    assign o_cmd.compare = (r_state == S_CMP);
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

FILE: rtl/sst_dp.sv
`timescale 1ns / 1ps
module sst_dp
    import sst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl_cmd        i_cmd,
    input  logic [OP_W-1:0]  i_op,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_valid,
    output logic [ST_W-1:0]  o_status,
    output logic [VAL_W-1:0] o_elem_out,
    output logic [POS_W-1:0] o_position,
    output logic [CNT_W-1:0] o_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [OP_W-1:0]  r_op;
    logic [WIDTH-1:0] r_val;
    logic [WIDTH-1:0] r_ent [DEPTH];
    logic [WIDTH-1:0] n_ent [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_cursor;
    logic [CW-1:0]    n_cursor;
    logic [DEPTH-1:0] r_lt;
    logic [DEPTH-1:0] r_eq;
    logic [WIDTH-1:0] r_rd;
    logic             w_found;
    logic [IW-1:0]    w_pos;
    t_status          w_status;
    logic [WIDTH-1:0] w_elem;
    logic             w_ins;
    logic             w_rem;

    logic             r_valid;
    logic [ST_W-1:0]  r_status;
    logic [VAL_W-1:0] r_elem_out;
    logic [POS_W-1:0] r_position;
    logic [CNT_W-1:0] r_count_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_val <= WIDTH'(i_value);
        end
    end

    // Per-entry compares, masked to the stored entries.
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_lt[i] <= (CW'(i) < r_count) && (r_ent[i] < r_val);
                r_eq[i] <= (CW'(i) < r_count) && (r_ent[i] == r_val);
            end
            if (t_op'(r_op) == OP_FIRST) begin
                r_rd <= r_ent[0];
            end else begin
                r_rd <= r_ent[r_cursor[IW-1:0]];
            end
        end
    end

    assign w_found = |r_eq;

    // Values are distinct, so at most one match bit is set.
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_eq[i]) begin
                w_pos = w_pos | IW'(i);
            end
        end
    end

    always_comb begin
        w_status = ST_OK;
        w_elem   = '0;
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        n_count  = r_count;
        n_cursor = r_cursor;
        case (t_op'(r_op))
            OP_INSERT: begin
                if (w_found) begin
                    w_status = ST_DUP;
                end else if (r_count == CW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!w_found) begin
                    w_status = ST_NOTFOUND;
                end else begin
                    w_rem   = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_SEARCH: begin
                if (!w_found) begin
                    w_status = ST_NOTFOUND;
                end
            end
            OP_FIRST: begin
                if (r_count == '0) begin
                    w_status = ST_END;
                end else begin
                    w_elem   = r_rd;
                    n_cursor = CW'(1);
                end
            end
            OP_NEXT: begin
                if (r_cursor >= r_count) begin
                    w_status = ST_END;
                end else begin
                    w_elem   = r_rd;
                    n_cursor = r_cursor + 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Insert opens a slot at the first entry not below the value; remove
    // pulls every entry from the match upward down by one.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_ent[i] = r_ent[i];
        end
        if (w_ins) begin
            if (!r_lt[0]) begin
                n_ent[0] = r_val;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (!r_lt[i]) begin
                    n_ent[i] = r_lt[i-1] ? r_val : r_ent[i-1];
                end
            end
        end else if (w_rem) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (!r_lt[i]) begin
                    n_ent[i] = r_ent[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_ent[i] <= n_ent[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_count  <= n_count;
                r_cursor <= n_cursor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status    <= w_status;
            r_elem_out  <= VAL_W'(w_elem);
            r_position  <= (t_op'(r_op) == OP_SEARCH && w_found) ? POS_W'(w_pos) : '0;
            r_count_out <= CNT_W'(n_count);
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_elem_out = r_elem_out;
    assign o_position = r_position;
    assign o_count    = r_count_out;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_set_table_core.
//
// A mirror of the sorted set, held in a small class, predicts the one result
// that every command transfer produces. The strobed results are compared
// field by field, in order, against those predictions.
module tb_top
    import sst_pkg::*;
();

    // One predicted result of a command transfer.
    typedef struct {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] elem;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } t_set_result;

    // Shapes of the random stimulus. Each episode leans toward one kind of work.
    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_WALK,
        MODE_MIXED
    } t_stim_mode;

    localparam int MAX_REPORTS = 40;

    // Mirror of the table contents plus the queue of results not yet seen.
    class sorted_set_mirror;
        logic [VAL_W-1:0] vals [DEPTH_DEF];
        int               count;
        int               cursor;
        t_set_result      pending_results [$];
        int               errors;
        int               accepted;
        int               checked;
        int               peak_count;
        int               status_seen [8];

        function new();
            count      = 0;
            cursor     = 0;
            errors     = 0;
            accepted   = 0;
            checked    = 0;
            peak_count = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        // Index of a stored value, or the count when it is absent.
        function int locate(logic [VAL_W-1:0] value);
            for (int k = 0; k < count; k++) begin
                if (vals[k] == value) return k;
            end
            return count;
        endfunction

        // A value that is in the set right now; the caller makes sure it is not empty.
        function logic [VAL_W-1:0] any_stored();
            return vals[$urandom_range(0, count - 1)];
        endfunction

        // Apply one accepted command to the mirror and queue its result.
        function void note_command(logic [OP_W-1:0] op, logic [VAL_W-1:0] value);
            t_set_result r;
            int          idx;
            int          slot;
            r.status = ST_OK;
            r.elem   = '0;
            r.pos    = '0;
            idx      = locate(value);
            accepted++;
            case (op)
                OP_INSERT: begin
                    // A duplicate is reported even when the table is full.
                    if (idx < count) begin
                        r.status = ST_DUP;
                    end else if (count >= DEPTH_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        slot = 0;
                        while (slot < count && vals[slot] < value) slot++;
                        for (int k = count; k > slot; k--) vals[k] = vals[k - 1];
                        vals[slot] = value;
                        count++;
                    end
                end
                OP_REMOVE: begin
                    if (idx >= count) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        for (int k = idx; k + 1 < count; k++) vals[k] = vals[k + 1];
                        count--;
                    end
                end
                OP_SEARCH: begin
                    if (idx >= count) r.status = ST_NOTFOUND;
                    else r.pos = idx[POS_W-1:0];
                end
                OP_FIRST: begin
                    if (count == 0) begin
                        r.status = ST_END;
                    end else begin
                        r.elem = vals[0];
                        cursor = 1;
                    end
                end
                OP_NEXT: begin
                    // The cursor may have been left past the end by removals.
                    if (cursor >= count) begin
                        r.status = ST_END;
                    end else begin
                        r.elem = vals[cursor];
                        cursor++;
                    end
                end
                default: begin
                end
            endcase
            r.count = count[CNT_W-1:0];
            if (count > peak_count) peak_count = count;
            status_seen[r.status]++;
            pending_results = {pending_results, r};
        endfunction

        function void report(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
            end
        endfunction

        // Compare one strobed result with the oldest prediction.
        function void check_result(logic [ST_W-1:0] status, logic [VAL_W-1:0] elem,
                                   logic [POS_W-1:0] pos, logic [CNT_W-1:0] cnt);
            t_set_result want;
            if (pending_results.size() == 0) begin
                report("unexpected result, status", '0, VAL_W'(status));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (status !== want.status) begin
                report("status", VAL_W'(want.status), VAL_W'(status));
            end
            if (elem !== want.elem) report("elem_out", want.elem, elem);
            if (pos !== want.pos) report("position", VAL_W'(want.pos), VAL_W'(pos));
            if (cnt !== want.count) report("count", VAL_W'(want.count), VAL_W'(cnt));
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [OP_W-1:0]  i_op;
    logic [VAL_W-1:0] i_value;
    logic             o_valid;
    logic [ST_W-1:0]  o_status;
    logic [VAL_W-1:0] o_elem_out;
    logic [POS_W-1:0] o_position;
    logic [CNT_W-1:0] o_count;

    sorted_set_mirror mirror;
    bit               gaps_on;

    sorted_set_table_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_elem_out (o_elem_out),
        .o_position (o_position),
        .o_count    (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The result port cannot be stalled, so every strobe is checked at the edge
    // that ends its cycle. Outputs are read before the design's own updates at
    // that edge land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            mirror.check_result(o_status, o_elem_out, o_position, o_count);
        end
    end

    // Present one command and hold it until a transfer happens. All inputs
    // change at the falling edge, and each one gets a single assignment per
    // edge, so start stays high without a glitch when commands run back to back.
    // While gaps are on, the command line idles before each command, going on
    // idling at each falling edge with a chance of about 35 in 100.
    task automatic send_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] value);
        while (gaps_on && $urandom_range(0, 99) < 35) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_op    <= op;
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        mirror.note_command(op, value);
    endtask

    // Operation mix per episode shape. A few percent of commands use the
    // unassigned op codes, which the block must ignore while still answering.
    function automatic logic [OP_W-1:0] pick_op(t_stim_mode mode);
        int r;
        int ins;
        int rem;
        int srch;
        int fst;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:   begin ins = 75; rem = 82; srch = 88; fst = 92; end
            MODE_SHRINK: begin ins = 15; rem = 70; srch = 80; fst = 86; end
            MODE_WALK:   begin ins = 10; rem = 18; srch = 25; fst = 35; end
            default:     begin ins = 30; rem = 55; srch = 75; fst = 83; end
        endcase
        if (r < ins) return OP_INSERT;
        if (r < rem) return OP_REMOVE;
        if (r < srch) return OP_SEARCH;
        if (r < fst) return OP_FIRST;
        if (r < 97) return OP_NEXT;
        return OP_W'($urandom_range(int'(OP_NEXT) + 1, (1 << OP_W) - 1));
    endfunction

    // Values: often one already stored (hits, duplicates, removals), often from
    // a small pool so that misses and re-inserts collide, sometimes an extreme,
    // and otherwise a full random word so every value bit toggles.
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && mirror.count > 0) return mirror.any_stored();
        if (r < 60) return VAL_W'($urandom_range(0, 40));
        if (r < 66) begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return '1;
                default: return {1'b1, {(VAL_W-1){1'b0}}};
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        int         drain_guard;
        int         left;
        t_stim_mode mode;

        mirror  = new();
        gaps_on = 1'b1;
        start   = 1'b0;
        i_op    = OP_INSERT;
        i_value = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening: empty-table corner cases, the value extremes,
        // duplicates, an ordered walk past the end, a cursor left beyond the
        // count by a removal, and the unassigned op codes.
        send_item(OP_FIRST, '0);
        send_item(OP_NEXT, '0);
        send_item(OP_SEARCH, '0);
        send_item(OP_REMOVE, 32'd5);
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, '0);
        send_item(OP_SEARCH, '1);
        send_item(OP_FIRST, '0);
        send_item(OP_NEXT, '0);
        send_item(OP_NEXT, '0);
        send_item(OP_NEXT, '0);
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_NEXT, '0);
        send_item(OP_SEARCH, 32'h8000_0000);
        send_item(OP_REMOVE, '0);
        send_item(OP_FIRST, '0);
        for (int k = int'(OP_NEXT) + 1; k < (1 << OP_W); k++) begin
            send_item(OP_W'(k), $urandom);
        end

        // Random episodes. The first one grows the set so the full table is
        // reached early; later ones pick a shape at random. One long stretch
        // runs with the command line never idling.
        left = $urandom_range(50, 70);
        mode = MODE_GROW;
        for (int n = 0; n < 1125; n++) begin
            if (left == 0) begin
                mode = t_stim_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 60);
            end
            left--;
            gaps_on = !(n >= 400 && n < 650);
            send_item(pick_op(mode), pick_value());
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Let the last results come out, then keep watching the result port to catch
        // any stray strobe.
        drain_guard = 0;
        while (mirror.pending_results.size() > 0 && drain_guard < 1000) begin
            @(posedge i_clk);
            drain_guard++;
        end
        repeat (8) @(posedge i_clk);
        if (mirror.pending_results.size() > 0) begin
            mirror.report("results never delivered, count", '0,
                          mirror.pending_results.size());
        end

        $display("Ran %0d commands, %0d results checked; largest set held %0d values.",
                 mirror.accepted, mirror.checked, mirror.peak_count);
        $display("Status mix: ok %0d, duplicate %0d, full %0d, not found %0d, end %0d.",
                 mirror.status_seen[ST_OK], mirror.status_seen[ST_DUP],
                 mirror.status_seen[ST_FULL], mirror.status_seen[ST_NOTFOUND],
                 mirror.status_seen[ST_END]);
        if (mirror.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: the full run needs well under a tenth of this time.
    initial begin
        #(2_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
